@@ sv/isr_pkg.sv @@
// ----------------------------------------------------------------------------
// isr_pkg
// Shared widths and the command type for the integer square root block.
// ----------------------------------------------------------------------------
`default_nettype none

package isr_pkg;

   // Radicand width as seen by the arithmetic (low bits of the field)
   localparam int RADICAND_WIDTH = 32;

   // Fixed field widths of the channels
   localparam int RADICAND_FIELD_WIDTH = 32;
   localparam int ROOT_FIELD_WIDTH     = 16;

   // Field sign-extended to at least the arithmetic width
   localparam int IN_EXT_WIDTH = (RADICAND_WIDTH > RADICAND_FIELD_WIDTH) ?
                                 RADICAND_WIDTH : RADICAND_FIELD_WIDTH;

   // A non-negative radicand has RADICAND_WIDTH-1 magnitude bits
   localparam int ROOT_WIDTH    = RADICAND_WIDTH / 2;
   localparam int OP_WIDTH      = 2 * ROOT_WIDTH;
   localparam int REM_WIDTH     = ROOT_WIDTH + 2;
   localparam int COUNT_WIDTH   = $clog2(ROOT_WIDTH + 1);

   // Root widened far enough to compare against the field maximum
   localparam int ROOT_EXT_WIDTH = (ROOT_WIDTH > ROOT_FIELD_WIDTH) ?
                                   ROOT_WIDTH : ROOT_FIELD_WIDTH;
   localparam int ROOT_MAX       = (1 << ROOT_FIELD_WIDTH) - 1;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic step;
      logic publish;
   } isr_cmd_type;

endpackage : isr_pkg

`default_nettype wire

@@ sv/isr_if.sv @@
// ----------------------------------------------------------------------------
// isr_req_if / isr_rsp_if
// Valid/ready channels carrying the radicand word and the root word.
// ----------------------------------------------------------------------------
`default_nettype none

interface isr_req_if;
   logic                                          valid;
   logic                                          ready;
   logic signed [isr_pkg::RADICAND_FIELD_WIDTH-1:0] radicand;

   modport source (output valid, output radicand, input ready);
   modport sink   (input valid, input radicand, output ready);
endinterface : isr_req_if

interface isr_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [isr_pkg::ROOT_FIELD_WIDTH-1:0]   root;
   logic                                   negative_input;

   modport source (output valid, output root, output negative_input, input ready);
   modport sink   (input valid, input root, input negative_input, output ready);
endinterface : isr_rsp_if

`default_nettype wire

@@ sv/integer_square_root.sv @@
// ----------------------------------------------------------------------------
// integer_square_root
// Floor square root of one signed radicand word per request.
// ----------------------------------------------------------------------------
// Each request word carries a two's complement radicand; the response word
// gives its floor square root and a negative_input flag (root reads 0 for a
// negative radicand). One word is worked on at a time: the root is built one
// bit per cycle by a shared trial-subtract unit. A word is loaded on
// acceptance, then takes one step per root bit, then its result moves into
// the output register once that register is free. A finished response
// waits in that register while the next request is already accepted and
// worked on. Every request gives exactly one response; nothing is kept
// between words.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_square_root (
   input  wire logic   clock,
   input  wire logic   reset,
   isr_req_if.sink     req_port,
   isr_rsp_if.source   rsp_port
);

   isr_pkg::isr_cmd_type cmd;

   isr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .cmd       (cmd)
   );

   isr_dp u_dp (
      .clock          (clock),
      .cmd            (cmd),
      .radicand       (req_port.radicand),
      .root           (rsp_port.root),
      .negative_input (rsp_port.negative_input)
   );

`ifndef SYNTHESIS
   a_negative_reads_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.negative_input) |-> (rsp_port.root == '0))
      else $error("negative radicand gave a nonzero root");

   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      (req_port.valid && req_port.ready) |=> !req_port.ready)
      else $error("second word accepted before the first one finished");

   a_root_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid |-> (isr_pkg::ROOT_WIDTH > isr_pkg::ROOT_FIELD_WIDTH ||
                          32'(rsp_port.root) < (32'd1 << isr_pkg::ROOT_WIDTH)))
      else $error("root wider than the radicand allows");
`endif

endmodule : integer_square_root

`default_nettype wire

@@ sv/isr_ctrl.sv @@
// ----------------------------------------------------------------------------
// isr_ctrl
// Sequencer: takes a word, runs one root digit per cycle, then hands the
// result to the output register once it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module isr_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      isr_pkg::isr_cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINISH
   } state_type;

   state_type                           state_ff, state_in;
   logic [isr_pkg::COUNT_WIDTH-1:0]     count_ff, count_in;
   logic                                rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               count_in = isr_pkg::COUNT_WIDTH'(isr_pkg::ROOT_WIDTH - 1);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (count_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               count_in = count_ff - 1'b1;
            end
         end
         ST_FINISH: begin
            // hold the root until the output register frees up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_RUN))
      else $error("accepted word did not start the digit loop");

   a_last_digit_finishes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && count_ff == '0) |=> (state_ff == ST_FINISH))
      else $error("digit loop did not end after the last digit");

   a_publish_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwrote a word still waiting at the output");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd))
      else $error("more than one datapath command at once");
`endif

endmodule : isr_ctrl

`default_nettype wire

@@ sv/isr_dp.sv @@
// ----------------------------------------------------------------------------
// isr_dp
// Digit-by-digit square root datapath: each step brings down two radicand
// bits, tries the next root bit against the partial remainder and keeps it
// when the trial subtraction does not borrow.
// ----------------------------------------------------------------------------
`default_nettype none

module isr_dp (
   input  wire logic                                          clock,
   input  wire isr_pkg::isr_cmd_type                          cmd,
   input  wire logic signed [isr_pkg::RADICAND_FIELD_WIDTH-1:0] radicand,
   output      logic [isr_pkg::ROOT_FIELD_WIDTH-1:0]          root,
   output      logic                                          negative_input
);

   localparam int RW = isr_pkg::REM_WIDTH;

   logic signed [isr_pkg::IN_EXT_WIDTH-1:0]  rad_ext;
   logic                                     rad_neg;
   logic [isr_pkg::OP_WIDTH-1:0]             val_ff;
   logic [RW-1:0]                            rem_ff;
   logic [isr_pkg::ROOT_WIDTH-1:0]           root_ff;
   logic                                     neg_ff;
   logic [RW-1:0]                            rem_shift;
   logic [RW-1:0]                            trial;
   logic [RW:0]                              diff;
   logic                                     take;
   logic [isr_pkg::ROOT_EXT_WIDTH-1:0]       root_ext;
   logic [isr_pkg::ROOT_FIELD_WIDTH-1:0]     root_sat;
   logic [isr_pkg::ROOT_FIELD_WIDTH-1:0]     root_out_ff;
   logic                                     neg_out_ff;

   // Take the low bits of the field as a two's complement radicand
   assign rad_ext = isr_pkg::IN_EXT_WIDTH'(radicand);
   assign rad_neg = rad_ext[isr_pkg::RADICAND_WIDTH-1];

   // Trial subtraction for the next root bit
   assign rem_shift = {rem_ff[isr_pkg::ROOT_WIDTH-1:0], val_ff[isr_pkg::OP_WIDTH-1 -: 2]};
   assign trial     = RW'({root_ff, 2'b01});
   assign diff      = {1'b0, rem_shift} - {1'b0, trial};
   assign take      = !diff[RW];

   // Saturate a root that does not fit the result field
   assign root_ext = isr_pkg::ROOT_EXT_WIDTH'(root_ff);
   assign root_sat = (root_ext > isr_pkg::ROOT_EXT_WIDTH'(isr_pkg::ROOT_MAX)) ?
                     isr_pkg::ROOT_FIELD_WIDTH'(isr_pkg::ROOT_MAX) :
                     isr_pkg::ROOT_FIELD_WIDTH'(root_ext);

   // Load, iterate, publish
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         val_ff  <= rad_neg ? '0 :
                    isr_pkg::OP_WIDTH'(rad_ext[isr_pkg::RADICAND_WIDTH-2:0]);
         rem_ff  <= '0;
         root_ff <= '0;
         neg_ff  <= rad_neg;
      end else if (cmd.step) begin
         val_ff  <= isr_pkg::OP_WIDTH'({val_ff, 2'b00});
         rem_ff  <= take ? diff[RW-1:0] : rem_shift;
         root_ff <= isr_pkg::ROOT_WIDTH'({root_ff, take});
      end
      if (cmd.publish) begin
         root_out_ff <= root_sat;
         neg_out_ff  <= neg_ff;
      end
   end

   assign root           = root_out_ff;
   assign negative_input = neg_out_ff;

endmodule : isr_dp

`default_nettype wire
